// File: src/wtg_pkg.sv
// Shared types, constants and the quarter-wave sine table for the tone generator.
// No dependencies; every other file in src imports this package.
package wtg_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;
  localparam logic [15:0] NOISE_SEED       = 16'hACE1;

  localparam logic [31:0] PHASE_STEP_RST   = 32'd8025146;
  localparam logic [15:0] GAIN_RST         = 16'd9830;

  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned CFG_IDX_W        = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_WAVE_SELECT = 2'd1,
    CFG_GAIN        = 2'd2,
    CFG_STEREO_ON   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_NOISE  = 2'd3
  } wave_sel_t;

  typedef struct packed {
    logic restart;
    logic end_of_block;
  } wtg_in_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               right_valid;
    logic               last_in_block;
  } wtg_out_t;

  // Wave point between the oscillator and the scaler; Q1.15 with +1.0 reachable
  typedef struct packed {
    logic signed [16:0] wave;
    logic               last_in_block;
  } wtg_wave_t;

  typedef logic [SINE_TABLE_DEPTH:0][16:0] sine_tab_t;

  // Floor quotient by shift and subtract; only used while building the table
  function automatic logic [63:0] udiv_elab(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // One quarter-wave entry: Taylor series in Q30, each product truncated
  function automatic logic [16:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) >> SINE_IDX_W;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = udiv_elab(term, 64'(2 * n) * 64'(2 * n + 1));
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[16:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_QUARTER = build_sine_tab();

endpackage

// File: src/waveform_tone_generator.sv
// Waveform tone generator: one audio frame per tick beat on a valid/ready stream.
// Depends on wtg_pkg, wtg_osc and wtg_scale.
//
// Usage:
//   Each input beat (restart, end_of_block) yields exactly one result beat
//   (left_sample, right_sample, right_valid, last_in_block), in order.
//   A 32-bit phase accumulator advances by phase_step per beat; restart zeroes
//   it before the frame. wave_select picks sine, sawtooth, square or noise;
//   gain scales the wave to a rounded, saturated Q1.15 sample.
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
//   write only while no beat is in flight.
//   Pipeline: an accepted beat passes the oscillator register, then the scaler
//   result register, before it appears on out_valid.
//   Throughput: one beat per clock while out_ready stays high; each of the two stages
//   passes a beat per cycle whenever the stage after it is empty or being drained.
//   Reset: registers return to their defaults, phase clears, the noise LFSR
//   reloads its seed and both stages empty.
//   Stall: with out_ready low, the result holds, the stage before it fills,
//   and in_ready drops after two beats are held.
module waveform_tone_generator
  import wtg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wtg_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output wtg_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [31:0] phase_step_r;
  wave_sel_t   wave_select_r;
  logic [15:0] gain_r;
  logic        stereo_on_r;
  logic        wave_valid;
  logic        wave_ready;
  wtg_wave_t   wave_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= PHASE_STEP_RST;
      wave_select_r <= WAVE_SINE;
      gain_r        <= GAIN_RST;
      stereo_on_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PHASE_STEP:  phase_step_r  <= cfg_wdata[31:0];
        CFG_WAVE_SELECT: wave_select_r <= wave_sel_t'(cfg_wdata[1:0]);
        CFG_GAIN:        gain_r        <= cfg_wdata[15:0];
        CFG_STEREO_ON:   stereo_on_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  wtg_osc u_osc (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .phase_step  (phase_step_r),
    .wave_select (wave_select_r),
    .wave_valid  (wave_valid),
    .wave_ready  (wave_ready),
    .wave_data   (wave_data)
  );

  wtg_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .wave_valid (wave_valid),
    .wave_ready (wave_ready),
    .wave_data  (wave_data),
    .gain       (gain_r),
    .stereo_on  (stereo_on_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: src/wtg_osc.sv
// Phase accumulator, noise LFSR and wave shaping; registers one wave point per beat.
// Depends on wtg_pkg for the sine table, wave codes and the beat structs.
module wtg_osc
  import wtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  wtg_in_t     in_data,
  input  logic [31:0] phase_step,
  input  wave_sel_t   wave_select,
  output logic        wave_valid,
  input  logic        wave_ready,
  output wtg_wave_t   wave_data
);

  logic [31:0]           phase_r;
  logic [31:0]           phase_nxt;
  logic [15:0]           lfsr_r;
  logic [15:0]           lfsr_nxt;
  logic                  wave_valid_r;
  logic                  wave_valid_nxt;
  wtg_wave_t             wave_r;
  wtg_wave_t             wave_nxt;
  logic                  accept;
  logic [31:0]           ph;
  logic [1:0]            quad;
  logic [SINE_IDX_W-1:0] k;
  logic [SINE_IDX_W:0]   tab_idx;
  logic [16:0]           mag;
  logic                  fb;

  assign in_ready   = !wave_valid_r || wave_ready;
  assign accept     = in_valid && in_ready;
  assign wave_valid = wave_valid_r;
  assign wave_data  = wave_r;

  // Restart clears the phase before this frame reads it
  assign ph      = in_data.restart ? 32'd0 : phase_r;
  assign quad    = ph[31:30];
  assign k       = ph[29 -: SINE_IDX_W];
  assign tab_idx = quad[0] ? (SINE_IDX_W+1)'(SINE_TABLE_DEPTH) - {1'b0, k} : {1'b0, k};
  assign mag     = SINE_QUARTER[tab_idx];
  assign fb      = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];

  always_comb begin
    phase_nxt          = phase_r;
    lfsr_nxt           = lfsr_r;
    wave_valid_nxt     = wave_valid_r;
    wave_nxt           = wave_r;
    if (wave_ready) begin
      wave_valid_nxt = 1'b0;
    end
    if (accept) begin
      phase_nxt               = ph + phase_step;
      wave_valid_nxt          = 1'b1;
      wave_nxt.last_in_block  = in_data.end_of_block;
      case (wave_select)
        WAVE_SINE: begin
          wave_nxt.wave = quad[1] ? -$signed(mag) : $signed(mag);
        end
        WAVE_SAW: begin
          // 2p-1 from the top phase bits, forced to zero at phase zero
          wave_nxt.wave = (ph == 32'd0) ? 17'sd0 :
                          $signed({~ph[31], ~ph[31], ph[30:16]});
        end
        WAVE_SQUARE: begin
          wave_nxt.wave = ph[31] ? -17'sd32768 : 17'sd32768;
        end
        WAVE_NOISE: begin
          // Step the LFSR only on noise frames
          lfsr_nxt      = {fb, lfsr_r[15:1]};
          wave_nxt.wave = $signed({2'b00, fb, lfsr_r[15:2]});
        end
        default: begin
          wave_nxt.wave = 17'sd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      lfsr_r       <= NOISE_SEED;
      wave_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      lfsr_r       <= lfsr_nxt;
      wave_valid_r <= wave_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wave_r <= wave_nxt;
  end

endmodule

// File: src/wtg_scale.sv
// Gain multiply, rounding and saturation to a Q1.15 sample; holds the result beat.
// Depends on wtg_pkg for the wave and result structs.
module wtg_scale
  import wtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wave_valid,
  output logic        wave_ready,
  input  wtg_wave_t   wave_data,
  input  logic [15:0] gain,
  input  logic        stereo_on,
  output logic        out_valid,
  input  logic        out_ready,
  output wtg_out_t    out_data
);

  logic               out_valid_r;
  logic               out_valid_nxt;
  wtg_out_t           out_r;
  wtg_out_t           out_nxt;
  logic signed [33:0] prod;
  logic signed [34:0] rounded;
  logic signed [18:0] shifted;
  logic signed [15:0] sample;

  assign wave_ready = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  assign prod    = wave_data.wave * $signed({1'b0, gain});
  assign rounded = 35'(prod) + 35'sd32768;
  assign shifted = 19'(rounded >>> 16);

  always_comb begin
    if (shifted > 19'sd32767) begin
      sample = 16'sh7FFF;
    end else if (shifted < -19'sd32768) begin
      sample = -16'sh8000;
    end else begin
      sample = shifted[15:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (wave_valid && wave_ready) begin
      out_valid_nxt         = 1'b1;
      out_nxt.left_sample   = sample;
      out_nxt.right_sample  = stereo_on ? sample : 16'sd0;
      out_nxt.right_valid   = stereo_on;
      out_nxt.last_in_block = wave_data.last_in_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: tb/wtg_checker.sv
`timescale 1ns / 100ps
// Frame checker for the tone generator: tracks register writes, predicts each frame
// from accepted tick beats and compares result beats in order. Depends on wtg_pkg.
module wtg_checker
  import wtg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  wtg_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  wtg_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           err_count,
  output int unsigned           frames_due,
  output int unsigned           frames_checked
);

  localparam int unsigned TAB_DEPTH        = 256;
  localparam logic [63:0] RIGHT_ANGLE_Q30  = 64'd1686629713;
  localparam logic [31:0] STEP_AT_RESET    = 32'd8025146;
  localparam logic [15:0] GAIN_AT_RESET    = 16'd9830;
  localparam logic [15:0] LFSR_SEED        = 16'hACE1;
  localparam int unsigned REPORT_CAP       = 40;

  int          quarter_tab [0:TAB_DEPTH];
  logic [31:0] phase_acc;
  logic [15:0] lfsr;
  logic [31:0] step_reg;
  wave_sel_t   wave_reg;
  logic [15:0] gain_reg;
  logic        stereo_reg;
  wtg_out_t    pending_frames [$];
  wtg_out_t    want;
  int unsigned errs = 0;
  int unsigned checked = 0;

  // Quarter-wave point k: Taylor series in Q30, every product truncated
  function automatic int taylor_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] r;
    x    = (64'(k) * RIGHT_ANGLE_Q30) / 64'(TAB_DEPTH);
    term = x;
    acc  = x;
    for (int unsigned n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return int'(r);
  endfunction

  initial begin
    for (int unsigned k = 0; k <= TAB_DEPTH; k++) begin
      quarter_tab[k] = taylor_sine(k);
    end
  end

  function automatic int sine_point(logic [31:0] ph);
    logic [63:0]  pos;
    int unsigned  quad;
    int unsigned  k;
    int           mag;
    pos  = (64'(ph) * 64'(4 * TAB_DEPTH)) >> 32;
    quad = int'(pos / TAB_DEPTH) % 4;
    k    = int'(pos % TAB_DEPTH);
    mag  = (quad % 2 == 1) ? quarter_tab[TAB_DEPTH - k] : quarter_tab[k];
    return (quad >= 2) ? -mag : mag;
  endfunction

  // Produce the frame for one tick beat and advance the oscillator
  function automatic wtg_out_t synth_frame(wtg_in_t beat);
    int       wave;
    longint   prod;
    longint   level;
    logic     fb;
    wtg_out_t f;
    if (beat.restart) begin
      phase_acc = '0;
    end
    case (wave_reg)
      WAVE_SINE:   wave = sine_point(phase_acc);
      WAVE_SAW:    wave = (phase_acc == '0) ? 0 : int'(phase_acc[31:16]) - 32768;
      WAVE_SQUARE: wave = phase_acc[31] ? -32768 : 32768;
      default: begin
        fb   = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
        lfsr = {fb, lfsr[15:1]};
        wave = int'(lfsr[15:1]);
      end
    endcase
    prod  = longint'(wave) * longint'(gain_reg) + 32768;
    level = prod >>> 16;
    if (level > 32767) begin
      level = 32767;
    end
    if (level < -32768) begin
      level = -32768;
    end
    f.left_sample   = 16'(level);
    f.right_sample  = stereo_reg ? 16'(level) : 16'sd0;
    f.right_valid   = stereo_reg;
    f.last_in_block = beat.end_of_block;
    phase_acc = phase_acc + step_reg;
    return f;
  endfunction

  function automatic void check_field(string name, logic signed [16:0] exp_v,
                                      logic signed [16:0] got_v);
    if (got_v !== exp_v) begin
      if (errs < REPORT_CAP) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      end
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      phase_acc  = '0;
      lfsr       = LFSR_SEED;
      step_reg   = STEP_AT_RESET;
      wave_reg   = WAVE_SINE;
      gain_reg   = GAIN_AT_RESET;
      stereo_reg = 1'b1;
      pending_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PHASE_STEP:  step_reg   = cfg_wdata[31:0];
          CFG_WAVE_SELECT: wave_reg   = wave_sel_t'(cfg_wdata[1:0]);
          CFG_GAIN:        gain_reg   = cfg_wdata[15:0];
          CFG_STEREO_ON:   stereo_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          if (errs < REPORT_CAP) begin
            $error("result beat with no frame pending: left_sample %0d",
                   out_data.left_sample);
          end
          errs++;
        end else begin
          want = pending_frames.pop_front();
          check_field("left_sample", want.left_sample, out_data.left_sample);
          check_field("right_sample", want.right_sample, out_data.right_sample);
          check_field("right_valid", want.right_valid, out_data.right_valid);
          check_field("last_in_block", want.last_in_block, out_data.last_in_block);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        pending_frames.push_back(synth_frame(in_data));
      end
    end
    err_count      <= errs;
    frames_due     <= pending_frames.size();
    frames_checked <= checked;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the tone generator bench: clock, reset, tick and register stimulus, verdict.
// Depends on wtg_pkg, waveform_tone_generator and wtg_checker.
module tb;
  import wtg_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  wtg_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  wtg_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned err_count;
  int unsigned frames_due;
  int unsigned frames_checked;
  int unsigned burst_left = 8;
  int unsigned beats_sent = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  waveform_tone_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  wtg_checker frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .err_count      (err_count),
    .frames_due     (frames_due),
    .frames_checked (frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: switch between always-ready, coin-flip, periodic and heavy stall
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rx_tick % 4 != 3);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the beat until accepted; drop valid for a gap at the end of a burst
  task automatic send_frame(input logic restart, input logic eob);
    in_valid <= 1'b1;
    in_data  <= '{restart: restart, end_of_block: eob};
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Stop sending and wait until every frame has come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] step, input wave_sel_t wave,
                           input logic [15:0] vol, input logic stereo,
                           input bit scramble);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] vals [4];
    cfg_idx_t              idx;
    junk = scramble ? $urandom() : '0;
    vals[CFG_PHASE_STEP]  = step;
    vals[CFG_WAVE_SELECT] = {junk[31:2], wave};
    vals[CFG_GAIN]        = {junk[31:16], vol};
    vals[CFG_STEREO_ON]   = {junk[31:1], stereo};
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[idx];
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    logic [31:0] step;
    logic [15:0] vol;
    int unsigned n;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PHASE_STEP;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: sine, stereo, both flags in every combination
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b1);
    send_frame(1'b0, 1'b0);
    send_frame(1'b1, 1'b1);
    drain();

    // Square at full gain: positive saturation, then a negative sample of -32767
    configure(32'h8000_0000, WAVE_SQUARE, 16'hFFFF, 1'b1, 1'b0);
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b0, 1'b1);
    drain();

    // Sawtooth: zero at phase zero, top of ramp with the largest step
    configure(32'hFFFF_FFFF, WAVE_SAW, 16'hFFFF, 1'b1, 1'b0);
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b0, 1'b1);
    drain();

    // Sine on quadrant boundaries, mono output
    configure(32'h4000_0000, WAVE_SINE, 16'hFFFF, 1'b0, 1'b0);
    send_frame(1'b1, 1'b0);
    repeat (4) send_frame(1'b0, 1'b0);
    drain();

    // Noise with a frozen phase
    configure(32'h0000_0000, WAVE_NOISE, 16'hFFFF, 1'b1, 1'b0);
    repeat (4) send_frame(1'b0, 1'b1);
    drain();

    for (int p = 0; p < 14; p++) begin
      case ($urandom_range(0, 5))
        0:       step = 32'h0000_0000;
        1:       step = 32'hFFFF_FFFF;
        2:       step = 32'h8000_0000;
        3:       step = $urandom_range(1, 1 << 20);
        default: step = $urandom();
      endcase
      case ($urandom_range(0, 3))
        0:       vol = 16'h0000;
        1:       vol = 16'hFFFF;
        default: vol = 16'($urandom());
      endcase
      configure(step, wave_sel_t'($urandom_range(0, 3)), vol, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      n = $urandom_range(60, 120);
      repeat (n) begin
        send_frame($urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d tick beats under %0d register settings plus reset defaults;",
             beats_sent, settings_run);
    $display("compared %0d frames across all four waves, mono and stereo.", frames_checked);
    if (err_count == 0 && frames_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
